/* rtl/fbcc_pkg.sv */
`timescale 1ns / 1ps

package fbcc_pkg;

   localparam int COUNT_BITS     = 24;
   localparam int INDEX_BITS     = 16;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

   localparam logic [7:0] CHAR_GT = 8'h3E;
   localparam logic [7:0] CHAR_NL = 8'h0A;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_EOF  = 1'b1;

   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      OP_SYM,
      OP_HDR,
      OP_EOF
   } op_code_type;

   typedef enum logic [1:0] {
      CLS_CG,
      CLS_AT,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] char_byte;
   } req_item_type;

   typedef struct packed {
      logic                  kind;
      logic [INDEX_BITS-1:0] seq_index;
      logic [COUNT_BITS-1:0] seq_length;
      logic [COUNT_BITS-1:0] cg_count;
      logic [COUNT_BITS-1:0] at_count;
      logic [COUNT_BITS-1:0] other_count;
      logic [COUNT_BITS-1:0] min_length;
      logic [COUNT_BITS-1:0] max_length;
      logic [COUNT_BITS-1:0] min_other;
      logic [COUNT_BITS-1:0] max_other;
      logic                  all_same_length;
      logic                  last;
   } rsp_item_type;

   // one decoded operation handed from front to back
   typedef struct packed {
      op_code_type op;
      cls_type     cls;
      logic        had_header;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/fbcc_queue.sv */
`timescale 1ns / 1ps

module fbcc_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  fbcc_pkg::queue_entry_type         push_entry,
   input  logic                              pop,
   output fbcc_pkg::queue_entry_type         head_entry,
   output fbcc_pkg::queue_status_type        status
);

   localparam int PB = fbcc_pkg::QUEUE_PTR_BITS;

   fbcc_pkg::queue_entry_type entries_ff [fbcc_pkg::QUEUE_DEPTH];
   logic [PB-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PB:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PB+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PB+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (PB+1)'(fbcc_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* rtl/fbcc_front.sv */
`timescale 1ns / 1ps

module fbcc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fbcc_pkg::req_item_type     req_data,
   input  fbcc_pkg::queue_status_type q_status,
   output logic                       push,
   output fbcc_pkg::queue_entry_type  push_entry
);

   logic in_header_ff, in_header_in;
   logic line_start_ff, line_start_in;
   logic seen_header_ff, seen_header_in;
   logic accept;
   logic want_push;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      in_header_in          = in_header_ff;
      line_start_in         = line_start_ff;
      seen_header_in        = seen_header_ff;
      want_push             = 1'b0;
      push_entry.op         = fbcc_pkg::OP_SYM;
      push_entry.had_header = seen_header_ff;
      case (req_data.char_byte)
         "C", "c", "G", "g": push_entry.cls = fbcc_pkg::CLS_CG;
         "A", "a", "T", "t": push_entry.cls = fbcc_pkg::CLS_AT;
         default:            push_entry.cls = fbcc_pkg::CLS_OTHER;
      endcase

      if (req_data.req_type == fbcc_pkg::REQ_EOF) begin
         want_push      = 1'b1;
         push_entry.op  = fbcc_pkg::OP_EOF;
         in_header_in   = 1'b0;
         line_start_in  = 1'b1;
         seen_header_in = 1'b0;
      end else if (req_data.char_byte == fbcc_pkg::CHAR_NL) begin
         in_header_in  = 1'b0;
         line_start_in = 1'b1;
      end else if (line_start_ff && req_data.char_byte == fbcc_pkg::CHAR_GT) begin
         want_push      = 1'b1;
         push_entry.op  = fbcc_pkg::OP_HDR;
         seen_header_in = 1'b1;
         in_header_in   = 1'b1;
         line_start_in  = 1'b0;
      end else begin
         line_start_in = 1'b0;
         // header text and bytes before the first header are dropped
         want_push     = !in_header_ff && seen_header_ff;
      end
   end

   assign push = accept && want_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff   <= 1'b0;
         line_start_ff  <= 1'b1;
         seen_header_ff <= 1'b0;
      end else if (accept) begin
         in_header_ff   <= in_header_in;
         line_start_ff  <= line_start_in;
         seen_header_ff <= seen_header_in;
      end
   end

endmodule

/* rtl/fbcc_back.sv */
`timescale 1ns / 1ps

module fbcc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fbcc_pkg::queue_entry_type  head_entry,
   input  fbcc_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fbcc_pkg::rsp_item_type     rsp_data
);

   localparam int CB = fbcc_pkg::COUNT_BITS;
   localparam int IB = fbcc_pkg::INDEX_BITS;
   localparam logic [CB-1:0] COUNT_MAX = '1;
   localparam logic [IB-1:0] INDEX_MAX = '1;

   logic [IB-1:0] seq_counter_ff;
   logic [CB-1:0] cur_length_ff, cur_cg_ff, cur_at_ff, cur_other_ff;
   logic [CB-1:0] len_min_ff, len_max_ff, other_min_ff, other_max_ff;
   logic [CB-1:0] first_length_ff;
   logic          uniform_ff;
   logic          eof_phase_ff, eof_phase_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   fbcc_pkg::rsp_item_type rsp_data_ff, out_item;

   logic can_out, needs_out, fire;
   logic do_sym, do_finish, do_clear, out_load;

   assign can_out = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      needs_out = 1'b0;
      case (head_entry.op)
         fbcc_pkg::OP_HDR: needs_out = head_entry.had_header;
         fbcc_pkg::OP_EOF: needs_out = 1'b1;
         default:          needs_out = 1'b0;
      endcase
   end

   assign fire = !q_status.empty && (!needs_out || can_out);

   // operation decode: symbol counts, record build shared by header and end-of-file, summary on end-of-file
   always_comb begin
      out_item = '0;
      do_sym       = 1'b0;
      do_finish    = 1'b0;
      do_clear     = 1'b0;
      out_load     = 1'b0;
      pop          = 1'b0;
      eof_phase_in = eof_phase_ff;
      if (fire) begin
         case (head_entry.op)
            fbcc_pkg::OP_SYM: begin
               do_sym = 1'b1;
               pop    = 1'b1;
            end
            fbcc_pkg::OP_HDR: begin
               pop      = 1'b1;
               do_clear = 1'b1;
               if (head_entry.had_header) begin
                  do_finish = 1'b1;
                  out_load  = 1'b1;
                  out_item.kind        = fbcc_pkg::KIND_RECORD;
                  out_item.seq_index   = seq_counter_ff - IB'(1);
                  out_item.seq_length  = cur_length_ff;
                  out_item.cg_count    = cur_cg_ff;
                  out_item.at_count    = cur_at_ff;
                  out_item.other_count = cur_other_ff;
                  out_item.last        = 1'b1;
               end
            end
            fbcc_pkg::OP_EOF: begin
               out_load = 1'b1;
               if (head_entry.had_header && !eof_phase_ff) begin
                  // open record first, summary on the next slot
                  do_finish    = 1'b1;
                  eof_phase_in = 1'b1;
                  out_item.kind        = fbcc_pkg::KIND_RECORD;
                  out_item.seq_index   = seq_counter_ff - IB'(1);
                  out_item.seq_length  = cur_length_ff;
                  out_item.cg_count    = cur_cg_ff;
                  out_item.at_count    = cur_at_ff;
                  out_item.other_count = cur_other_ff;
                  out_item.last        = 1'b0;
               end else begin
                  pop          = 1'b1;
                  eof_phase_in = 1'b0;
                  out_item.kind      = fbcc_pkg::KIND_SUMMARY;
                  out_item.seq_index = seq_counter_ff;
                  if (head_entry.had_header) begin
                     out_item.min_length = len_min_ff;
                     out_item.max_length = len_max_ff;
                     out_item.min_other  = other_min_ff;
                     out_item.max_other  = other_max_ff;
                  end
                  out_item.all_same_length = uniform_ff;
                  out_item.last            = 1'b1;
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         eof_phase_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         eof_phase_ff <= eof_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // counters and file statistics
   always_ff @(posedge clock) begin
      if (reset || (pop && head_entry.op == fbcc_pkg::OP_EOF)) begin
         seq_counter_ff  <= '0;
         cur_length_ff   <= '0;
         cur_cg_ff       <= '0;
         cur_at_ff       <= '0;
         cur_other_ff    <= '0;
         len_min_ff      <= COUNT_MAX;
         len_max_ff      <= '0;
         other_min_ff    <= COUNT_MAX;
         other_max_ff    <= '0;
         first_length_ff <= '0;
         uniform_ff      <= 1'b1;
      end else begin
         if (do_finish) begin
            if (cur_length_ff < len_min_ff)  len_min_ff   <= cur_length_ff;
            if (cur_length_ff > len_max_ff)  len_max_ff   <= cur_length_ff;
            if (cur_other_ff < other_min_ff) other_min_ff <= cur_other_ff;
            if (cur_other_ff > other_max_ff) other_max_ff <= cur_other_ff;
            if (seq_counter_ff == IB'(1)) begin
               first_length_ff <= cur_length_ff;
            end else if (cur_length_ff != first_length_ff) begin
               uniform_ff <= 1'b0;
            end
         end
         if (do_clear) begin
            if (seq_counter_ff != INDEX_MAX) seq_counter_ff <= seq_counter_ff + IB'(1);
            cur_length_ff <= '0;
            cur_cg_ff     <= '0;
            cur_at_ff     <= '0;
            cur_other_ff  <= '0;
         end
         if (do_sym) begin
            if (cur_length_ff != COUNT_MAX) cur_length_ff <= cur_length_ff + CB'(1);
            case (head_entry.cls)
               fbcc_pkg::CLS_CG: begin
                  if (cur_cg_ff != COUNT_MAX) cur_cg_ff <= cur_cg_ff + CB'(1);
               end
               fbcc_pkg::CLS_AT: begin
                  if (cur_at_ff != COUNT_MAX) cur_at_ff <= cur_at_ff + CB'(1);
               end
               default: begin
                  if (cur_other_ff != COUNT_MAX) cur_other_ff <= cur_other_ff + CB'(1);
               end
            endcase
         end
      end
   end

endmodule

/* rtl/fasta_base_composition_counter_unit.sv */
`timescale 1ns / 1ps
// The result of a transaction that ends a record goes through the queue write, then the
// result register, before it is valid, when the queue is empty.
// Throughput: one byte per cycle unless the queue is full; end of file after a header
// emits two results. Back-end update sets the rate, one queue entry per unstalled cycle.
// Reset: synchronous, active high; clears parser, queue, counters and output valid.
module fasta_base_composition_counter_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fbcc_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fbcc_pkg::rsp_item_type rsp_data
);

   // Front end: tracks line start / header state and turns each byte into
   // a symbol, header or end-of-file operation. Newlines, header text and
   // bytes before the first header never reach the queue.
   logic                       q_push;
   fbcc_pkg::queue_entry_type  q_push_entry;
   fbcc_pkg::queue_entry_type  q_head;
   fbcc_pkg::queue_status_type q_status;
   logic                       q_pop;

   fbcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_status   (q_status),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // Short queue decouples byte intake from result backpressure.
   fbcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .status     (q_status)
   );

   // Back end: saturating counters, min/max/uniform statistics and the
   // registered result slot. End of file after headers emits the open
   // record, then the summary, and returns all statistics to reset.
   fbcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (q_head),
      .q_status   (q_status),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/sv/fasta_base_composition_counter_unit_tb.sv */
`timescale 1ns / 1ps

module fasta_base_composition_counter_unit_tb;

   localparam int CB = fbcc_pkg::COUNT_BITS;
   localparam int IB = fbcc_pkg::INDEX_BITS;

   // run control
   localparam int CYCLE_LIMIT  = 100_000;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 175;
   localparam int MAX_REPORTS  = 10;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   fbcc_pkg::req_item_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   fbcc_pkg::rsp_item_type rsp_data;

   fasta_base_composition_counter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Composition tally: the testbench's own picture of the parser
   // and the per-file statistics.
   // ---------------------------------------------------------------
   logic          hdr_open;
   logic          line_start;
   logic          got_header;
   logic [IB-1:0] headers_seen;
   logic [CB-1:0] sym_len, sym_cg, sym_at, sym_other;
   logic [CB-1:0] shortest, longest, fewest_other, most_other;
   logic [CB-1:0] first_len;
   logic          lengths_equal;

   // record and summary reports still owed by the block, oldest first
   fbcc_pkg::rsp_item_type awaited_reports[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;
   int mismatches     = 0;
   int cycle_count    = 0;

   // long receiver hold-off: main bumps the token, receiver does the counting
   int hold_token  = 0;
   int hold_served = 0;
   int hold_left   = 0;

   // directed stimulus; typed expectations stand in for the tally's
   typedef struct {
      fbcc_pkg::req_item_type item;
      int                     n_typed;
      fbcc_pkg::rsp_item_type typed0;
      fbcc_pkg::rsp_item_type typed1;
   } stim_row_type;

   stim_row_type directed_rows[$];

   function automatic void clear_tally();
      hdr_open      = 1'b0;
      line_start    = 1'b1;
      got_header    = 1'b0;
      headers_seen  = '0;
      sym_len       = '0;
      sym_cg        = '0;
      sym_at        = '0;
      sym_other     = '0;
      shortest      = '1;
      longest       = '0;
      fewest_other  = '1;
      most_other    = '0;
      first_len     = '0;
      lengths_equal = 1'b1;
   endfunction

   function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
      return (v == '1) ? v : v + CB'(1);
   endfunction

   function automatic fbcc_pkg::cls_type classify_symbol(input logic [7:0] c);
      case (c)
         "C", "c", "G", "g": return fbcc_pkg::CLS_CG;
         "A", "a", "T", "t": return fbcc_pkg::CLS_AT;
         default:            return fbcc_pkg::CLS_OTHER;
      endcase
   endfunction

   // report the open record and fold it into the file statistics
   function automatic fbcc_pkg::rsp_item_type close_record(input logic last_flag);
      fbcc_pkg::rsp_item_type r;
      r             = '0;
      r.kind        = fbcc_pkg::KIND_RECORD;
      r.seq_index   = headers_seen - IB'(1);
      r.seq_length  = sym_len;
      r.cg_count    = sym_cg;
      r.at_count    = sym_at;
      r.other_count = sym_other;
      r.last        = last_flag;
      if (sym_len < shortest) shortest = sym_len;
      if (sym_len > longest) longest = sym_len;
      if (sym_other < fewest_other) fewest_other = sym_other;
      if (sym_other > most_other) most_other = sym_other;
      if (headers_seen == IB'(1)) first_len = sym_len;
      else if (sym_len != first_len) lengths_equal = 1'b0;
      return r;
   endfunction

   // advance the tally by one accepted transaction; returns reports queued
   function automatic int tally_item(input fbcc_pkg::req_item_type it);
      int                     n;
      fbcc_pkg::rsp_item_type s;
      n = 0;
      if (it.req_type == fbcc_pkg::REQ_EOF) begin
         if (got_header) begin
            awaited_reports.push_back(close_record(1'b0));
            n = 1;
         end
         s           = '0;
         s.kind      = fbcc_pkg::KIND_SUMMARY;
         s.seq_index = headers_seen;
         if (got_header) begin
            s.min_length = shortest;
            s.max_length = longest;
            s.min_other  = fewest_other;
            s.max_other  = most_other;
         end
         s.all_same_length = lengths_equal;
         s.last            = 1'b1;
         awaited_reports.push_back(s);
         clear_tally();
         return n + 1;
      end
      if (it.char_byte == fbcc_pkg::CHAR_NL) begin
         hdr_open   = 1'b0;
         line_start = 1'b1;
         return 0;
      end
      if (line_start && it.char_byte == fbcc_pkg::CHAR_GT) begin
         if (got_header) begin
            awaited_reports.push_back(close_record(1'b1));
            n = 1;
         end
         got_header = 1'b1;
         if (headers_seen != '1) headers_seen = headers_seen + IB'(1);
         sym_len    = '0;
         sym_cg     = '0;
         sym_at     = '0;
         sym_other  = '0;
         hdr_open   = 1'b1;
         line_start = 1'b0;
         return n;
      end
      line_start = 1'b0;
      // header text and anything before the first header are not symbols
      if (hdr_open || !got_header) return 0;
      sym_len = sat_inc(sym_len);
      case (classify_symbol(it.char_byte))
         fbcc_pkg::CLS_CG: sym_cg    = sat_inc(sym_cg);
         fbcc_pkg::CLS_AT: sym_at    = sat_inc(sym_at);
         default:          sym_other = sat_inc(sym_other);
      endcase
      return 0;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic fbcc_pkg::req_item_type byte_req(input logic [7:0] c);
      fbcc_pkg::req_item_type r;
      r.req_type  = fbcc_pkg::REQ_BYTE;
      r.char_byte = c;
      return r;
   endfunction

   function automatic fbcc_pkg::req_item_type eof_req(input logic [7:0] c);
      fbcc_pkg::req_item_type r;
      r.req_type  = fbcc_pkg::REQ_EOF;
      r.char_byte = c;
      return r;
   endfunction

   function automatic fbcc_pkg::rsp_item_type rec_rsp(input int idx, input int len,
                                                      input int cg, input int at,
                                                      input int oth, input logic lst);
      fbcc_pkg::rsp_item_type r;
      r             = '0;
      r.kind        = fbcc_pkg::KIND_RECORD;
      r.seq_index   = IB'(idx);
      r.seq_length  = CB'(len);
      r.cg_count    = CB'(cg);
      r.at_count    = CB'(at);
      r.other_count = CB'(oth);
      r.last        = lst;
      return r;
   endfunction

   function automatic fbcc_pkg::rsp_item_type sum_rsp(input int cnt, input int minl,
                                                      input int maxl, input int mino,
                                                      input int maxo, input logic same);
      fbcc_pkg::rsp_item_type r;
      r                 = '0;
      r.kind            = fbcc_pkg::KIND_SUMMARY;
      r.seq_index       = IB'(cnt);
      r.min_length      = CB'(minl);
      r.max_length      = CB'(maxl);
      r.min_other       = CB'(mino);
      r.max_other       = CB'(maxo);
      r.all_same_length = same;
      r.last            = 1'b1;
      return r;
   endfunction

   function automatic void add_row(input fbcc_pkg::req_item_type it, input int n = 0,
                                   input fbcc_pkg::rsp_item_type r0 = '0,
                                   input fbcc_pkg::rsp_item_type r1 = '0);
      directed_rows.push_back('{it, n, r0, r1});
   endfunction

   function automatic string rsp_text(input fbcc_pkg::rsp_item_type r);
      return $sformatf({"kind=%0d idx=%0d len=%0d cg=%0d at=%0d oth=%0d ",
                        "minl=%0d maxl=%0d mino=%0d maxo=%0d same=%0d last=%0d"},
                       r.kind, r.seq_index, r.seq_length, r.cg_count, r.at_count,
                       r.other_count, r.min_length, r.max_length, r.min_other,
                       r.max_other, r.all_same_length, r.last);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // mostly bases, some IUPAC codes and gaps, some raw bytes;
   // a clean symbol never breaks the line
   function automatic logic [7:0] pick_symbol(input bit clean);
      string      bases = "ACGTacgt";
      string      codes = "NnRYKMSWBDHV-.*";
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: c = bases[$urandom_range(0, 7)];
         6, 7:             c = codes[$urandom_range(0, codes.len() - 1)];
         default:          c = rand_byte();
      endcase
      if (clean && c == fbcc_pkg::CHAR_NL) c = "N";
      return c;
   endfunction

   // Offer one transaction. Called at a falling edge, returns at one.
   // Valid is written once per falling edge; the payload holds while stalled.
   task automatic send_item(input fbcc_pkg::req_item_type it, input int n_typed = 0,
                            input fbcc_pkg::rsp_item_type t0 = '0,
                            input fbcc_pkg::rsp_item_type t1 = '0);
      int n;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      // accepted at this edge
      n = tally_item(it);
      if (n_typed > 0) begin
         // hand-typed expectation replaces what the tally queued
         repeat (n) void'(awaited_reports.pop_back());
         awaited_reports.push_back(t0);
         if (n_typed > 1) awaited_reports.push_back(t1);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
   endtask

   // One file: mostly well-formed records with random content, plus stray
   // bytes before the first header, lines missing their newline and raw noise.
   task automatic send_random_file();
      int         n_rec;
      int         n_lines;
      int         line_len;
      int         fixed_len;
      bit         fixed;
      logic [7:0] hb;
      n_rec     = $urandom_range(0, 5);
      // equal single-line records so the uniform-length flag ends up set
      fixed     = ($urandom_range(99) < 30);
      fixed_len = $urandom_range(0, 10);
      if ($urandom_range(99) < 20)
         repeat ($urandom_range(1, 3)) send_item(byte_req(rand_byte()));
      for (int r = 0; r < n_rec; r++) begin
         send_item(byte_req(fbcc_pkg::CHAR_GT));
         repeat ($urandom_range(0, 5)) begin
            hb = rand_byte();
            if (hb == fbcc_pkg::CHAR_NL) hb = "x";
            send_item(byte_req(hb));
         end
         send_item(byte_req(fbcc_pkg::CHAR_NL));
         n_lines = fixed ? 1 : $urandom_range(0, 3);
         for (int l = 0; l < n_lines; l++) begin
            line_len = fixed ? fixed_len : $urandom_range(0, 12);
            repeat (line_len) send_item(byte_req(pick_symbol(fixed)));
            // a missing newline turns the next '>' into a symbol
            if (fixed || $urandom_range(99) < 92) send_item(byte_req(fbcc_pkg::CHAR_NL));
         end
      end
      send_item(eof_req(rand_byte()));
   endtask

   // ---------------------------------------------------------------
   // Receiver: random stall plus the long hold-off on request
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_token != hold_served) begin
         hold_served = hold_token;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // Result check: every accepted result against the oldest awaited report
   // ---------------------------------------------------------------
   always @(posedge clock) begin : report_check
      fbcc_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: %s", rsp_text(rsp_data));
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_data.kind            !== want.kind            ||
                rsp_data.seq_index       !== want.seq_index       ||
                rsp_data.seq_length      !== want.seq_length      ||
                rsp_data.cg_count        !== want.cg_count        ||
                rsp_data.at_count        !== want.at_count        ||
                rsp_data.other_count     !== want.other_count     ||
                rsp_data.min_length      !== want.min_length      ||
                rsp_data.max_length      !== want.max_length      ||
                rsp_data.min_other       !== want.min_other       ||
                rsp_data.max_other       !== want.max_other       ||
                rsp_data.all_same_length !== want.all_same_length ||
                rsp_data.last            !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("mismatch expected: %s", rsp_text(want));
                  $display("           actual: %s", rsp_text(rsp_data));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("fasta_base_composition_counter_unit test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin : main_seq
      int idle_send[4];
      int idle_recv[4];
      int target;

      idle_send = '{0, 63, 0, 11};
      idle_recv = '{0, 0, 63, 11};
      clear_tally();

      // empty file straight out of reset; the byte on end of file is ignored
      add_row(eof_req(8'hFF), 1, sum_rsp(0, 0, 0, 0, 0, 1'b1));
      // stray byte ahead of the first header is dropped
      add_row(byte_req("A"));
      add_row(byte_req(fbcc_pkg::CHAR_NL));
      add_row(byte_req(fbcc_pkg::CHAR_GT));
      // '>' inside a header is plain header text
      add_row(byte_req(fbcc_pkg::CHAR_GT));
      add_row(byte_req("h"));
      add_row(byte_req(fbcc_pkg::CHAR_NL));
      add_row(byte_req("A"));
      add_row(byte_req("c"));
      add_row(byte_req("G"));
      add_row(byte_req("t"));
      add_row(byte_req("N"));
      add_row(byte_req("-"));
      // '>' in mid line counts as an other symbol
      add_row(byte_req(fbcc_pkg::CHAR_GT));
      add_row(byte_req(8'h00));
      add_row(byte_req(8'hFF));
      add_row(byte_req(fbcc_pkg::CHAR_NL));
      add_row(byte_req(fbcc_pkg::CHAR_NL));
      add_row(byte_req(fbcc_pkg::CHAR_GT), 1, rec_rsp(0, 9, 2, 2, 5, 1'b1));
      add_row(byte_req(fbcc_pkg::CHAR_NL));
      add_row(byte_req("g"));
      add_row(byte_req("a"));
      // open record closes first, then the summary
      add_row(eof_req(8'h00), 2, rec_rsp(1, 2, 1, 1, 0, 1'b0),
              sum_rsp(2, 2, 9, 0, 5, 1'b0));
      // one empty record
      add_row(byte_req(fbcc_pkg::CHAR_GT));
      add_row(eof_req(8'h5A), 2, rec_rsp(0, 0, 0, 0, 0, 1'b0),
              sum_rsp(1, 0, 0, 0, 0, 1'b1));
      add_row(eof_req(8'hA5), 1, sum_rsp(0, 0, 0, 0, 0, 1'b1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].n_typed,
                   directed_rows[i].typed0, directed_rows[i].typed1);

      // random files under each idling profile
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_send[p];
         recv_stall_pct = idle_recv[p];
         target         = items_sent + PHASE_ITEMS;
         if (p == 0) begin
            // receiver holds off while transactions keep coming: the block
            // fills and stalls its input; then the sender waits for all
            // reports before going on
            hold_token++;
            while (items_sent < target - 95) send_random_file();
            wait_drained();
         end
         while (items_sent < target) send_random_file();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && awaited_reports.size() == 0) begin
         $display("fasta_base_composition_counter_unit test passed");
      end else begin
         $display("fasta_base_composition_counter_unit test failed");
      end
      $finish;
   end

endmodule
